[hw/rtl/swf_pkg.sv]
// Shared constants for the square waypoint follower: position format,
// angle constants, action codes and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swf_pkg;

	localparam int POS_FRAC_BITS = 10;
	localparam int POS_WIDTH     = 20;

	localparam int SIDE_W  = 6;
	localparam int LAPS_W  = 8;
	localparam int TOL_W   = 14;
	localparam int RAD_W   = 12;
	localparam int SPEED_W = 8;
	localparam int ANG_W   = 9;
	localparam int HEAD_W  = 15;

	localparam int UNIT_W = SIDE_W + POS_FRAC_BITS;
	localparam int DIFF_W = ((UNIT_W + 1 > POS_WIDTH) ? UNIT_W + 1 : POS_WIDTH) + 1;
	localparam int SQ_W   = 2 * RAD_W;
	localparam int ERR_W  = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [HEAD_W-1:0] DEG360_H = 15'd23040;
	localparam logic [ERR_W-1:0]  DEG360   = 16'd23040;
	localparam logic [ERR_W-1:0]  DEG90    = 16'd5760;

	typedef logic [1:0] action_t;
	localparam action_t ACT_ADVANCE = 2'd0;
	localparam action_t ACT_TURN    = 2'd1;
	localparam action_t ACT_DRIVE   = 2'd2;
	localparam action_t ACT_FINISH  = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_SIDE_LENGTH       = 3'd0;
	localparam cfg_idx_t REG_TARGET_LAPS       = 3'd1;
	localparam cfg_idx_t REG_HEADING_TOLERANCE = 3'd2;
	localparam cfg_idx_t REG_ARRIVAL_RADIUS    = 3'd3;
	localparam cfg_idx_t REG_DRIVE_SPEED       = 3'd4;
	localparam cfg_idx_t REG_TURN_SPEED        = 3'd5;

endpackage

`default_nettype wire

[hw/rtl/square_waypoint_follower.sv]
// Top level of the square waypoint follower: pose register, decision logic,
// corner and lap state, result register. Depends on swf_pkg.
//
//   channel  signals                                  direction
//   in       in_valid, in_stall, pos_x, pos_y, heading  pose beats in
//   out      out_valid, out_stall, action .. finished   result beats out
//   cfg      cfg_wr_en, cfg_index, cfg_data           register writes in
//
// One pose beat is accepted per cycle while in_stall is low; its result passes
// through the pose register and then the result register around the decision logic.
// Reset clears corner, lap count and held commands and loads register defaults.
// A stalled result holds the pose register; input stall rises only while both
// registers are full and the output is stalled.
`timescale 1ns / 1ps
`default_nettype none

module square_waypoint_follower
	import swf_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [POS_WIDTH-1:0]  pos_x,
	input  wire logic signed [POS_WIDTH-1:0]  pos_y,
	input  wire logic signed [HEAD_W-1:0]     heading,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output action_t                           action,
	output logic [SPEED_W-1:0]                linear_cmd,
	output logic signed [ANG_W-1:0]           angular_cmd,
	output logic [1:0]                        corner_now,
	output logic [LAPS_W-1:0]                 laps_now,
	output logic                              finished,
	input  wire logic                         cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

	logic [SIDE_W-1:0]  side_length_q;
	logic [LAPS_W-1:0]  target_laps_q;
	logic [TOL_W-1:0]   heading_tolerance_q;
	logic [RAD_W-1:0]   arrival_radius_q;
	logic [SPEED_W-1:0] drive_speed_q;
	logic [SPEED_W-1:0] turn_speed_q;

	logic [1:0]              corner_q;
	logic [LAPS_W-1:0]       laps_q;
	logic [SPEED_W-1:0]      held_linear_q;
	logic signed [ANG_W-1:0] held_angular_q;

	logic                        valid_s1;
	logic signed [POS_WIDTH-1:0] pos_x_s1;
	logic signed [POS_WIDTH-1:0] pos_y_s1;
	logic signed [HEAD_W-1:0]    heading_s1;

	logic advance_s1;
	logic load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_length_q       <= SIDE_W'(1);
			target_laps_q       <= LAPS_W'(1);
			heading_tolerance_q <= TOL_W'(32);
			arrival_radius_q    <= RAD_W'(72);
			drive_speed_q       <= SPEED_W'(22);
			turn_speed_q        <= SPEED_W'(20);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SIDE_LENGTH:       side_length_q       <= cfg_data[SIDE_W-1:0];
				REG_TARGET_LAPS:       target_laps_q       <= cfg_data[LAPS_W-1:0];
				REG_HEADING_TOLERANCE: heading_tolerance_q <= cfg_data[TOL_W-1:0];
				REG_ARRIVAL_RADIUS:    arrival_radius_q    <= cfg_data[RAD_W-1:0];
				REG_DRIVE_SPEED:       drive_speed_q       <= cfg_data[SPEED_W-1:0];
				REG_TURN_SPEED:        turn_speed_q        <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance_s1 = valid_s1 && (!out_valid || !out_stall);
	assign in_stall   = valid_s1 && !advance_s1;
	assign load_s1    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pos_x_s1   <= pos_x;
			pos_y_s1   <= pos_y;
			heading_s1 <= heading;
		end
	end

	logic [UNIT_W-1:0]       unit;
	logic signed [DIFF_W-1:0] goal_x, goal_y, px_w, py_w, diff_x, diff_y;
	logic [DIFF_W-1:0]       abs_x, abs_y, rad_w;
	logic [SQ_W-1:0]         sq_x, sq_y, sq_r;
	logic [SQ_W:0]           sq_sum;
	logic                    near;

	assign unit   = {side_length_q, {POS_FRAC_BITS{1'b0}}};
	assign goal_x = (corner_q == 2'd0 || corner_q == 2'd1) ? DIFF_W'(unit) : '0;
	assign goal_y = (corner_q == 2'd1 || corner_q == 2'd2) ? DIFF_W'(unit) : '0;
	assign px_w   = {{(DIFF_W - POS_WIDTH){pos_x_s1[POS_WIDTH-1]}}, pos_x_s1};
	assign py_w   = {{(DIFF_W - POS_WIDTH){pos_y_s1[POS_WIDTH-1]}}, pos_y_s1};
	assign diff_x = goal_x - px_w;
	assign diff_y = goal_y - py_w;
	assign abs_x  = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
	assign abs_y  = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
	assign rad_w  = DIFF_W'(arrival_radius_q);

	assign sq_x   = abs_x[RAD_W-1:0] * abs_x[RAD_W-1:0];
	assign sq_y   = abs_y[RAD_W-1:0] * abs_y[RAD_W-1:0];
	assign sq_r   = arrival_radius_q * arrival_radius_q;
	assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
	assign near   = (abs_x < rad_w) && (abs_y < rad_w) && (sq_sum < {1'b0, sq_r});

	logic [HEAD_W-1:0]       yaw;
	logic signed [ERR_W-1:0] err_raw;
	logic [ERR_W-1:0]        target_ang, err, err_rev, tol_w;
	logic                    facing;

	assign yaw        = heading_s1[HEAD_W-1] ? HEAD_W'(heading_s1) + DEG360_H
	                                         : HEAD_W'(heading_s1);
	assign target_ang = ERR_W'(corner_q) * DEG90;
	assign err_raw    = $signed(target_ang) - $signed(ERR_W'(yaw));
	assign err        = err_raw[ERR_W-1] ? ERR_W'(err_raw) + DEG360 : ERR_W'(err_raw);
	assign err_rev    = DEG360 - err;
	assign tol_w      = ERR_W'(heading_tolerance_q);
	assign facing     = (err < tol_w) || (err_rev < tol_w);

	action_t                 act_n;
	logic [1:0]              corner_n;
	logic [LAPS_W-1:0]       laps_n;
	logic [SPEED_W-1:0]      linear_n;
	logic signed [ANG_W-1:0] angular_n;
	logic signed [ANG_W-1:0] turn_pos;

	assign turn_pos = $signed({1'b0, turn_speed_q});

	always_comb begin
		act_n     = ACT_DRIVE;
		corner_n  = corner_q;
		laps_n    = laps_q;
		linear_n  = held_linear_q;
		angular_n = held_angular_q;
		priority if (laps_q == target_laps_q) begin
			act_n = ACT_FINISH;
		end else if (near) begin
			act_n    = ACT_ADVANCE;
			corner_n = corner_q + 2'd1;
			if (corner_q == 2'd3) begin
				laps_n = laps_q + LAPS_W'(1);
			end
		end else if (!facing) begin
			act_n     = ACT_TURN;
			linear_n  = '0;
			angular_n = (err_rev < DEG90) ? -turn_pos : turn_pos;
		end else begin
			act_n     = ACT_DRIVE;
			linear_n  = drive_speed_q;
			angular_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q       <= '0;
			laps_q         <= '0;
			held_linear_q  <= '0;
			held_angular_q <= '0;
			out_valid      <= 1'b0;
		end else begin
			if (advance_s1) begin
				corner_q       <= corner_n;
				laps_q         <= laps_n;
				held_linear_q  <= linear_n;
				held_angular_q <= angular_n;
				out_valid      <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			action      <= act_n;
			linear_cmd  <= linear_n;
			angular_cmd <= angular_n;
			corner_now  <= corner_n;
			laps_now    <= laps_n;
			finished    <= (act_n == ACT_FINISH);
		end
	end

`ifndef ASSERT_OFF
	a_finish_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (finished == (action == ACT_FINISH)))
		else $error("finished flag disagrees with action");

	a_corner_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && act_n == ACT_ADVANCE) |=> (corner_q == $past(corner_q) + 2'd1))
		else $error("corner did not step on advance");

	a_lap_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(laps_q != $past(laps_q)) |-> (corner_q == 2'd0))
		else $error("lap counted away from the first corner");

	a_turn_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && action == ACT_TURN) |-> (linear_cmd == '0))
		else $error("forward command while turning");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

[tb/sv/square_waypoint_follower_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for square_waypoint_follower: pose beats in, decision beats out,
// each result compared field by field against a cycle-free decision predictor.
// Depends on swf_pkg and the square_waypoint_follower RTL.

module square_waypoint_follower_tb;
	import swf_pkg::*;

	localparam int FULL_TURN = DEG360;
	localparam int QUARTER_TURN = DEG90;
	localparam int HALF_TURN = FULL_TURN / 2;
	localparam int METER = 1 << POS_FRAC_BITS;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 80;
	localparam int SEGMENT_BEATS = 175;
	localparam cfg_idx_t REG_SPARE_LO = 3'd6;
	localparam cfg_idx_t REG_SPARE_HI = 3'd7;

	typedef enum logic [0:0] {AT_ABS, AT_GOAL} anchor_t;

	typedef struct packed {
		anchor_t anchor;
		int      px;
		int      py;
		int      hd;
	} pose_req_t;

	typedef struct packed {
		logic [POS_WIDTH-1:0] x;
		logic [POS_WIDTH-1:0] y;
		logic [HEAD_W-1:0]    h;
	} pose_t;

	typedef struct packed {
		action_t             act;
		logic [SPEED_W-1:0]  lin;
		logic [ANG_W-1:0]    ang;
		logic [1:0]          corner;
		logic [LAPS_W-1:0]   laps;
		logic                fin;
	} decision_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [POS_WIDTH-1:0] pos_x = '0;
	logic signed [POS_WIDTH-1:0] pos_y = '0;
	logic signed [HEAD_W-1:0]    heading = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	action_t                     action;
	logic [SPEED_W-1:0]          linear_cmd;
	logic signed [ANG_W-1:0]     angular_cmd;
	logic [1:0]                  corner_now;
	logic [LAPS_W-1:0]           laps_now;
	logic                        finished;
	logic                        cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	// Register shadows, loaded with the reset defaults.
	logic [SIDE_W-1:0]  side_reg = 6'd1;
	logic [LAPS_W-1:0]  target_reg = 8'd1;
	logic [TOL_W-1:0]   tol_reg = 14'd32;
	logic [RAD_W-1:0]   radius_reg = 12'd72;
	logic [SPEED_W-1:0] drive_reg = 8'd22;
	logic [SPEED_W-1:0] turn_reg = 8'd20;

	logic [1:0]              goal_corner = '0;
	logic [LAPS_W-1:0]       lap_count = '0;
	logic [SPEED_W-1:0]      held_lin = '0;
	logic signed [ANG_W-1:0] held_ang = '0;

	pose_req_t pose_q[$];
	decision_t decision_q[$];
	pose_t     next_pose;
	decision_t want;

	int tx_idle_pct = 14;
	int rx_idle_pct = 53;
	int hold_left = 0;
	int holds_asked = 0;
	int holds_granted = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	int reg_writes = 0;
	int lap_wraps = 0;
	int act_seen[4] = '{0, 0, 0, 0};

	square_waypoint_follower dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint goal_coord(logic [1:0] k, bit y_axis);
		bit on_side;
		on_side = y_axis ? (k == 2'd1 || k == 2'd2) : (k == 2'd0 || k == 2'd1);
		return on_side ? (longint'(side_reg) << POS_FRAC_BITS) : longint'(0);
	endfunction

	function automatic decision_t decide_pose(logic signed [POS_WIDTH-1:0] px,
			logic signed [POS_WIDTH-1:0] py, logic signed [HEAD_W-1:0] hd);
		decision_t d;
		longint    ex, ey, rad;
		int        yaw, err;
		bit        near_goal, facing;
		d = '0;
		if (lap_count == target_reg) begin
			d.act = ACT_FINISH;
			d.fin = 1'b1;
		end else begin
			ex = goal_coord(goal_corner, 1'b0) - longint'(px);
			ey = goal_coord(goal_corner, 1'b1) - longint'(py);
			if (ex < 0) ex = -ex;
			if (ey < 0) ey = -ey;
			rad = longint'(radius_reg);
			near_goal = ex < rad && ey < rad && ex * ex + ey * ey < rad * rad;
			yaw = int'(hd);
			if (yaw < 0) yaw += FULL_TURN;
			err = int'(goal_corner) * QUARTER_TURN - yaw;
			if (err < 0) err += FULL_TURN;
			facing = err < int'(tol_reg) || FULL_TURN - err < int'(tol_reg);
			if (near_goal) begin
				d.act = ACT_ADVANCE;
				goal_corner = goal_corner + 2'd1;
				if (goal_corner == 2'd0) begin
					lap_count = lap_count + 8'd1;
					if (lap_count == '0) lap_wraps++;
				end
			end else if (!facing) begin
				d.act = ACT_TURN;
				held_lin = '0;
				held_ang = (FULL_TURN - err < QUARTER_TURN) ? -$signed({1'b0, turn_reg})
					: $signed({1'b0, turn_reg});
			end else begin
				d.act = ACT_DRIVE;
				held_lin = drive_reg;
				held_ang = '0;
			end
		end
		d.lin = held_lin;
		d.ang = held_ang;
		d.corner = goal_corner;
		d.laps = lap_count;
		return d;
	endfunction

	// Offsets of a goal-anchored request are taken from the corner the predictor holds when the beat
	// is offered, after every beat accepted so far.
	function automatic pose_t aim_pose(pose_req_t rq);
		pose_t p;
		int    hd;
		if (rq.anchor == AT_ABS) begin
			p.x = POS_WIDTH'(rq.px);
			p.y = POS_WIDTH'(rq.py);
			p.h = HEAD_W'(rq.hd);
		end else begin
			p.x = POS_WIDTH'(goal_coord(goal_corner, 1'b0) + longint'(rq.px));
			p.y = POS_WIDTH'(goal_coord(goal_corner, 1'b1) + longint'(rq.py));
			hd = int'(goal_corner) * QUARTER_TURN + rq.hd;
			if (hd > HALF_TURN) hd -= FULL_TURN;
			if (hd < -HALF_TURN) hd += FULL_TURN;
			p.h = HEAD_W'(hd);
		end
		return p;
	endfunction

	function automatic int spread(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	task automatic add_abs(int x, int y, int h);
		pose_q.push_back('{AT_ABS, x, y, h});
	endtask

	task automatic add_goal(int ox, int oy, int oh);
		pose_q.push_back('{AT_GOAL, ox, oy, oh});
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		reg_writes++;
		case (idx)
			REG_SIDE_LENGTH: side_reg = val[SIDE_W-1:0];
			REG_TARGET_LAPS: target_reg = val[LAPS_W-1:0];
			REG_HEADING_TOLERANCE: tol_reg = val[TOL_W-1:0];
			REG_ARRIVAL_RADIUS: radius_reg = val[RAD_W-1:0];
			REG_DRIVE_SPEED: drive_reg = val[SPEED_W-1:0];
			REG_TURN_SPEED: turn_reg = val[SPEED_W-1:0];
			default: ;
		endcase
	endtask

	// The queues are looked at between edges, where the driver and monitor have settled.
	task automatic settle();
		@(negedge clk);
		while (pose_q.size() != 0 || in_valid || decision_q.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_config();
		write_reg(REG_SIDE_LENGTH, CFG_DATA_W'($urandom_range(16383)));
		write_reg(REG_TARGET_LAPS, CFG_DATA_W'(lap_count + 2 + $urandom_range(28)));
		write_reg(REG_HEADING_TOLERANCE, ($urandom_range(3) == 0)
			? CFG_DATA_W'($urandom_range(11520)) : CFG_DATA_W'($urandom_range(1500, 1)));
		write_reg(REG_ARRIVAL_RADIUS, CFG_DATA_W'($urandom_range(4095, 1)));
		write_reg(REG_DRIVE_SPEED, CFG_DATA_W'($urandom_range(255)));
		write_reg(REG_TURN_SPEED, CFG_DATA_W'($urandom_range(255)));
	endtask

	// Mostly legs toward the current corner that end inside the arrival circle,
	// mixed with raw poses and legs that need not arrive.
	task automatic random_segment(int beats);
		int n, legs, span;
		n = 0;
		while (n < beats) begin
			if ($urandom_range(99) < 15) begin
				add_abs(int'($urandom), int'($urandom), int'($urandom));
				n++;
			end else begin
				legs = $urandom_range(4);
				for (int k = 0; k < legs; k++) begin
					span = ($urandom_range(1) == 1) ? 65535 : 2 * int'(radius_reg) + 1;
					add_goal(spread(span), spread(span), ($urandom_range(1) == 1)
						? spread(int'(tol_reg)) : spread(HALF_TURN));
				end
				n += legs;
				if ($urandom_range(99) < 85) begin
					add_goal(spread(int'(radius_reg) / 2), spread(int'(radius_reg) / 2),
						spread(HALF_TURN));
					n++;
				end
			end
		end
	endtask

	task automatic check_field(string name, longint expv, logic signed [ANG_W:0] got);
		if ($isunknown(got) || got != expv) begin
			$error("%s: expected %0d, got %0d", name, expv, got);
			mismatches++;
		end
	endtask

	// Pose driver: record the accepted beat first, then offer the next one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decision_q.push_back(decide_pose(pos_x, pos_y, heading));
				beats_in++;
			end
			if (!in_valid || !in_stall) begin
				if (pose_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_pose = aim_pose(pose_q.pop_front());
					pos_x <= next_pose.x;
					pos_y <= next_pose.y;
					heading <= next_pose.h;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (holds_granted != holds_asked) begin
				out_stall <= 1'b1;
				hold_left <= LONG_HOLD;
				holds_granted <= holds_asked;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_out++;
			if (decision_q.size() == 0) begin
				$error("result beat with no pose beat pending");
				mismatches++;
			end else begin
				want = decision_q.pop_front();
				act_seen[want.act]++;
				check_field("action", longint'(want.act), action);
				check_field("linear_cmd", longint'(want.lin), linear_cmd);
				check_field("angular_cmd", longint'($signed(want.ang)), angular_cmd);
				check_field("corner_now", longint'(want.corner), corner_now);
				check_field("laps_now", longint'(want.laps), laps_now);
				check_field("finished", longint'(want.fin), finished);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("FAIL square_waypoint_follower");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Default registers: one lap of a one meter square, then finished.
		add_abs(0, 0, 0);
		add_abs(524287, -524288, 11520);
		add_abs(-524288, 524287, -11520);
		add_abs(0, 0, 100);
		add_abs(0, 0, 16383);
		add_abs(0, 0, -16384);
		add_abs(0, 0, 20);
		add_abs(METER + 50, 30, 0);
		add_abs(METER, METER + 72, QUARTER_TURN);
		add_abs(METER - 60, METER - 40, 0);
		add_abs(METER + 71, METER, QUARTER_TURN);
		add_abs(0, METER, HALF_TURN);
		add_abs(0, 0, -QUARTER_TURN);
		add_abs(0, 0, 0);
		settle();

		// Zero side, zero tolerance, zero radius; writes to unused indexes change nothing.
		write_reg(REG_SIDE_LENGTH, '0);
		write_reg(REG_TARGET_LAPS, 14'd3);
		write_reg(REG_HEADING_TOLERANCE, '0);
		write_reg(REG_ARRIVAL_RADIUS, '0);
		write_reg(REG_SPARE_LO, 14'h3FFF);
		write_reg(REG_SPARE_HI, 14'h3FFF);
		add_abs(0, 0, 0);
		add_abs(5, -5, -1);
		add_abs(0, 0, HALF_TURN);
		settle();

		write_reg(REG_SIDE_LENGTH, 14'd63);
		write_reg(REG_HEADING_TOLERANCE, 14'h3FFF);
		write_reg(REG_ARRIVAL_RADIUS, 14'd4095);
		write_reg(REG_DRIVE_SPEED, 14'd255);
		write_reg(REG_TURN_SPEED, 14'd255);
		add_abs(63 * METER + 4000, 0, 0);
		add_abs(63 * METER, 63 * METER + 4095, 0);
		add_abs(-524288, -524288, -16384);
		settle();
		write_reg(REG_HEADING_TOLERANCE, '0);
		add_abs(0, 0, 100);
		add_abs(0, 0, QUARTER_TURN + 100);
		settle();

		random_config();
		random_segment(SEGMENT_BEATS);
		settle();
		random_config();
		random_segment(SEGMENT_BEATS);
		settle();

		tx_idle_pct = 53;
		rx_idle_pct = 14;
		random_config();
		random_segment(SEGMENT_BEATS);
		settle();
		random_config();
		random_segment(SEGMENT_BEATS);
		settle();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// A target one below the lap count leaves the block counting laps past it.
		write_reg(REG_SIDE_LENGTH, '0);
		write_reg(REG_ARRIVAL_RADIUS, 14'd4095);
		write_reg(REG_TARGET_LAPS, CFG_DATA_W'(lap_count - 8'd1));
		for (int k = 0; k < 8; k++) add_goal(spread(2000), spread(2000), spread(HALF_TURN));
		settle();

		random_config();
		holds_asked++;
		random_segment(SEGMENT_BEATS);
		settle();
		random_config();
		random_segment(SEGMENT_BEATS / 2);
		settle();
		random_segment(SEGMENT_BEATS / 2);
		settle();
		repeat (8) @(posedge clk);

		$display("Run covered %0d pose beats and %0d result beats around %0d register writes.",
			beats_in, beats_out, reg_writes);
		$display("Advances %0d, turns %0d, drives %0d, finishes %0d, lap counter wraps %0d.",
			act_seen[ACT_ADVANCE], act_seen[ACT_TURN], act_seen[ACT_DRIVE],
			act_seen[ACT_FINISH], lap_wraps);
		if (mismatches == 0) begin
			$display("PASS square_waypoint_follower");
		end else begin
			$display("FAIL square_waypoint_follower");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/swf_pkg.sv
hw/rtl/square_waypoint_follower.sv
tb/sv/square_waypoint_follower_tb.sv
